@@ hdl/wtlp_pkg.sv @@
// shared types, constants and codes of the waypoint trail loop pruner
`timescale 1ns / 1ps

package wtlp_pkg;

   // coordinate and distance widths
   localparam int COORD_W = 24;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQR_W   = 2 * COORD_W;
   localparam int SQ_W    = 50;
   localparam int OUT_W   = 2;

   // trail depth limits and defaults
   localparam int DEPTH_DEFAULT = 16;
   localparam int DEPTH_MAX     = 256;
   localparam int IDX_MAX_W     = $clog2(DEPTH_MAX);
   localparam int LEN_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

   // cycles from a query entering a cell to that cell's verdict in its carry register
   localparam int CHAIN_LAT = 4;

   // reset value of the squared spacing: (3.0 m in Q16.8) squared
   localparam logic [SQ_W-1:0] SPACING_SQ_RESET = SQ_W'(589824);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } pos_type;

   // search verdict passed down the chain, newest entry first
   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] idx;
   } carry_type;

   // append request broadcast to all cells
   typedef struct packed {
      logic                 en;
      logic [IDX_MAX_W-1:0] idx;
      pos_type              pos;
   } write_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_IGNORED = 2'd0,
      OUT_NEAR    = 2'd1,
      OUT_TRUNC   = 2'd2,
      OUT_APPEND  = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/wtlp_req_if.sv @@
// position channel: valid/ready with one 3-D position per transfer
`timescale 1ns / 1ps

interface wtlp_req_if;
   import wtlp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] position_x;
   logic signed [COORD_W-1:0] position_y;
   logic signed [COORD_W-1:0] position_z;

   modport source (output valid, output position_x, output position_y, output position_z,
                   input ready);
   modport sink   (input valid, input position_x, input position_y, input position_z,
                   output ready);
endinterface

@@ hdl/wtlp_rsp_if.sv @@
// result channel: valid/ready with outcome and trail length per transfer
`timescale 1ns / 1ps

interface wtlp_rsp_if #(
   parameter int LEN_W = wtlp_pkg::LEN_W_DEFAULT
);
   import wtlp_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] outcome;
   logic [LEN_W-1:0] trail_length;

   modport source (output valid, output outcome, output trail_length, input ready);
   modport sink   (input valid, input outcome, input trail_length, output ready);
endinterface

@@ hdl/wtlp_cell.sv @@
// one trail cell: holds a waypoint, checks the passing query against it
`timescale 1ns / 1ps

module wtlp_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = wtlp_pkg::LEN_W_DEFAULT
) (
   input  logic                      clock,
   input  wtlp_pkg::pos_type         q_up,
   output wtlp_pkg::pos_type         q_down,
   input  wtlp_pkg::carry_type       carry_up,
   output wtlp_pkg::carry_type       carry_down,
   input  logic [wtlp_pkg::SQ_W-1:0] spacing_sq,
   input  logic [CNT_W-1:0]          trail_count,
   input  wtlp_pkg::write_type       entry_wr
);
   import wtlp_pkg::*;

   pos_type                  q_ff, q_in;
   pos_type                  ent_ff, ent_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [2*DIFF_W-1:0] px, py, pz;
   logic [SQR_W-1:0]         sx_ff, sx_in, sy_ff, sy_in, sz_ff, sz_in;
   logic [SQ_W-1:0]          sum_ff, sum_in;
   carry_type                carry_ff, carry_in;
   logic                     live, near;

   // query moves one cell down per cycle
   assign q_in = q_up;

   // stored waypoint, written on append to this slot
   assign ent_in = (entry_wr.en && (entry_wr.idx == IDX_MAX_W'(IDX))) ? entry_wr.pos : ent_ff;

   // per-axis differences
   assign dx_in = DIFF_W'(q_ff.x) - DIFF_W'(ent_ff.x);
   assign dy_in = DIFF_W'(q_ff.y) - DIFF_W'(ent_ff.y);
   assign dz_in = DIFF_W'(q_ff.z) - DIFF_W'(ent_ff.z);

   // squares, each below 2^48
   assign px    = dx_ff * dx_ff;
   assign py    = dy_ff * dy_ff;
   assign pz    = dz_ff * dz_ff;
   assign sx_in = px[SQR_W-1:0];
   assign sy_in = py[SQR_W-1:0];
   assign sz_in = pz[SQR_W-1:0];

   // squared distance
   assign sum_in = SQ_W'(sx_ff) + SQ_W'(sy_ff) + SQ_W'(sz_ff);

   // first hit from the newest side wins
   assign live = CNT_W'(IDX) < trail_count;
   assign near = sum_ff <= spacing_sq;

   always_comb begin
      carry_in = carry_up;
      if (!carry_up.hit && near && live) begin
         carry_in.hit = 1'b1;
         carry_in.idx = IDX_MAX_W'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      ent_ff   <= ent_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sz_ff    <= sz_in;
      sum_ff   <= sum_in;
      carry_ff <= carry_in;
   end

   assign q_down     = q_ff;
   assign carry_down = carry_ff;

endmodule

@@ hdl/wtlp_ctrl.sv @@
// sequencer: takes positions, times the chain search, updates the trail, holds results
`timescale 1ns / 1ps

module wtlp_ctrl #(
   parameter int TRAIL_DEPTH = wtlp_pkg::DEPTH_DEFAULT,
   parameter int CNT_W       = $clog2(TRAIL_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   wtlp_req_if.sink                  req_ch,
   wtlp_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [wtlp_pkg::SQ_W-1:0] csr_wr_data,
   output wtlp_pkg::pos_type         qry,
   output logic [wtlp_pkg::SQ_W-1:0] spacing_sq,
   output logic [CNT_W-1:0]          trail_count,
   input  wtlp_pkg::carry_type       chain_result,
   output wtlp_pkg::write_type       entry_wr
);
   import wtlp_pkg::*;

   localparam int SCAN_LAST = TRAIL_DEPTH + CHAIN_LAT;
   localparam int SCAN_W    = $clog2(SCAN_LAST + 1);

   state_type         st_ff, st_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   pos_type           qry_ff, qry_in;
   logic [SQ_W-1:0]   spacing_ff, spacing_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  res_count_ff, res_count_in;
   outcome_type       res_out_ff, res_out_in;
   outcome_type       out_ff, out_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              valid_ff, valid_in;
   logic [CNT_W-1:0]  hit_len;
   logic              req_take, commit, full, scan_done;

   assign full      = count_ff == CNT_W'(TRAIL_DEPTH);
   assign req_take  = req_ch.valid && req_ch.ready;
   assign scan_done = scan_ff == SCAN_W'(SCAN_LAST);
   assign hit_len   = CNT_W'(chain_result.idx) + CNT_W'(1);
   assign commit    = (st_ff == ST_FINISH) && (!valid_ff || rsp_ch.ready);

   // next state and search bookkeeping
   always_comb begin
      st_in        = st_ff;
      scan_in      = scan_ff;
      qry_in       = qry_ff;
      res_out_in   = res_out_ff;
      res_count_in = res_count_ff;
      req_ch.ready = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_take) begin
               qry_in.x = req_ch.position_x;
               qry_in.y = req_ch.position_y;
               qry_in.z = req_ch.position_z;
               scan_in  = '0;
               if (full) begin
                  res_out_in   = OUT_IGNORED;
                  res_count_in = count_ff;
                  st_in        = ST_FINISH;
               end else begin
                  st_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_done) begin
               scan_in = scan_ff;
               st_in   = ST_FINISH;
               if (!chain_result.hit) begin
                  res_out_in   = OUT_APPEND;
                  res_count_in = count_ff + CNT_W'(1);
               end else if (hit_len == count_ff) begin
                  res_out_in   = OUT_NEAR;
                  res_count_in = count_ff;
               end else begin
                  res_out_in   = OUT_TRUNC;
                  res_count_in = hit_len;
               end
            end
         end
         ST_FINISH: begin
            if (commit) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // trail length, result register and spacing register
   assign count_in   = commit ? res_count_ff : count_ff;
   assign valid_in   = commit ? 1'b1 : (rsp_ch.ready ? 1'b0 : valid_ff);
   assign out_in     = commit ? res_out_ff : out_ff;
   assign len_in     = commit ? res_count_ff : len_ff;
   assign spacing_in = csr_wr_en ? csr_wr_data : spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         scan_ff    <= '0;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
         spacing_ff <= SPACING_SQ_RESET;
      end else begin
         st_ff      <= st_in;
         scan_ff    <= scan_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
         spacing_ff <= spacing_in;
      end
   end

   always_ff @(posedge clock) begin
      qry_ff       <= qry_in;
      res_out_ff   <= res_out_in;
      res_count_ff <= res_count_in;
      out_ff       <= out_in;
      len_ff       <= len_in;
   end

   // append goes into the slot just past the current end
   assign entry_wr.en  = commit && (res_out_ff == OUT_APPEND);
   assign entry_wr.idx = IDX_MAX_W'(count_ff);
   assign entry_wr.pos = qry_ff;

   assign qry          = qry_ff;
   assign spacing_sq   = spacing_ff;
   assign trail_count  = count_ff;

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.outcome      = out_ff;
   assign rsp_ch.trail_length = len_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TRAIL_DEPTH))
      else $error("trail length beyond depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      entry_wr.en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the trail by one");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_FINISH |=> $stable(count_ff))
      else $error("trail length changed outside commit");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(st_ff == ST_FINISH))
      else $error("result raised without a finished item");
`endif

endmodule

@@ hdl/waypoint_trail_loop_pruner_unit.sv @@
// top level: waypoint trail loop pruner, a chain of trail cells and its sequencer
//
// req_ch carries one signed Q16.8 position (x, y, z) per transfer, rsp_ch returns
// one result per position: outcome (ignored, near last, truncated, appended) and
// the trail length after the item. csr_wr_en/csr_wr_data write the squared
// minimum spacing; write it only while no item is in flight.
// Each stored waypoint sits in its own cell; the query travels down the chain
// from the newest slot toward slot 0, one cell per cycle, and each cell adds its
// verdict to a carry that follows behind it through the cell's difference, square
// and sum registers. The chain length sets the search time, and a new position
// is taken only once the result of the last one has been committed. With a full
// trail the position is ignored without a search. Reset empties the trail and
// loads a spacing of 3.0 m squared; stored waypoints are not cleared. The result
// sits in an output register: a stalled receiver does not block the next search,
// only its commit waits for the slot to free.
`timescale 1ns / 1ps

module waypoint_trail_loop_pruner_unit #(
   parameter int TRAIL_DEPTH = wtlp_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   wtlp_req_if.sink                  req_ch,
   wtlp_rsp_if.source                rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [wtlp_pkg::SQ_W-1:0] csr_wr_data
);
   import wtlp_pkg::*;

   localparam int CNT_W = $clog2(TRAIL_DEPTH + 1);

   pos_type          q_link     [TRAIL_DEPTH+1];
   carry_type        carry_link [TRAIL_DEPTH+1];
   logic [SQ_W-1:0]  spacing_sq;
   logic [CNT_W-1:0] trail_count;
   write_type        entry_wr;

   // search starts at the newest end with no hit
   assign carry_link[TRAIL_DEPTH] = '0;

   wtlp_ctrl #(
      .TRAIL_DEPTH (TRAIL_DEPTH),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .qry          (q_link[TRAIL_DEPTH]),
      .spacing_sq   (spacing_sq),
      .trail_count  (trail_count),
      .chain_result (carry_link[0]),
      .entry_wr     (entry_wr)
   );

   // row of cells, slot TRAIL_DEPTH-1 at the head of the chain
   for (genvar i = 0; i < TRAIL_DEPTH; i++) begin : g_cell
      wtlp_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .q_up        (q_link[i+1]),
         .q_down      (q_link[i]),
         .carry_up    (carry_link[i+1]),
         .carry_down  (carry_link[i]),
         .spacing_sq  (spacing_sq),
         .trail_count (trail_count),
         .entry_wr    (entry_wr)
      );
   end

endmodule
